// File: design/cpd_pkg.sv
// ============================================================================
// cpd_pkg: shared constants and types for the gated complex phase block
// Widths, the CORDIC arctangent table and the per-stage side-band type.
// ============================================================================
package cpd_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int GUARD_SHIFT  = 16;
  localparam int TABLE_LEN    = 24;
  localparam int ANGLE_STAGES = 18;
  localparam int NUM_ITER     = (ANGLE_STAGES > TABLE_LEN) ? TABLE_LEN : ANGLE_STAGES;

  localparam int THR_W      = 23;
  localparam int THR_SQ_W   = 2 * THR_W;
  localparam int THR_RESET  = 128;
  localparam int PHASE_W    = 15;
  localparam int XY_W       = SAMPLE_BITS + GUARD_SHIFT + 3;
  localparam int Z_W        = 26;
  localparam int ATAN_W     = 23;
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int PWR_W      = SQ_W + 1;
  localparam int RND_SHIFT  = 10;
  localparam int RND_HALF   = 512;
  localparam int RND_W      = Z_W - RND_SHIFT;

  localparam int HALF_TURN_FINE = 180 * 65536;
  localparam int HALF_TURN_OUT  = 11520;
  localparam int FULL_TURN_OUT  = 23040;

  // atan(2^-i) in degrees, scaled by 65536 and rounded to nearest.
  localparam logic [ATAN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
    23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
  };

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  z_t;

  typedef struct packed {
    logic last;
    logic zero;
    logic gated;
  } side_t;

endpackage

// File: design/cpd_in_if.sv
// ============================================================================
// cpd_in_if: input word channel
// One complex point per word with a block-end marker.
// ============================================================================
interface cpd_in_if import cpd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] real_part;
  logic signed [SAMPLE_BITS-1:0] imag_part;
  logic                          last_point;

  modport source (output valid, real_part, imag_part, last_point, input ready);
  modport sink   (input valid, real_part, imag_part, last_point, output ready);
endinterface

// File: design/cpd_out_if.sv
// ============================================================================
// cpd_out_if: result word channel
// Phase in 1/64 degree, gating flag and block-end marker.
// ============================================================================
interface cpd_out_if import cpd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] phase_deg;
  logic                      below_threshold;
  logic                      last_out;

  modport source (output valid, phase_deg, below_threshold, last_out, input ready);
  modport sink   (input valid, phase_deg, below_threshold, last_out, output ready);
endinterface

// File: design/gated_complex_phase_degrees_top.sv
// ============================================================================
// gated_complex_phase_degrees_top: pipelined CORDIC atan2 phase with gating
// Returns atan2(imag, real) in 1/64 degree, zeroed below a magnitude threshold.
// ============================================================================
// The block accepts one word per clock unless the output stalls, and returns
// one result word per input word, in order. Each of the 18 CORDIC iterations
// is its own register stage; the input stage does the half-plane fold and the
// squares, the last two stages round and wrap the angle. Every stage moves on
// its own when the stage after it is free, so bubbles close up and a stalled
// output still lets the pipeline fill. A threshold write goes through thr_r,
// then thr_sq_r; the user makes it only while idle, the block does not check.
module gated_complex_phase_degrees_top import cpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data,
  cpd_in_if.sink           in_chan,
  cpd_out_if.source        out_chan
);

  localparam int RND_STG = NUM_ITER + 1;
  localparam int OUT_STG = NUM_ITER + 2;
  localparam int NSTG    = NUM_ITER + 3;

  localparam logic signed [RND_W-1:0]   R_HALF   = RND_W'(HALF_TURN_OUT);
  localparam logic signed [RND_W-1:0]   R_FULL   = RND_W'(FULL_TURN_OUT);
  localparam logic signed [PHASE_W-1:0] PH_MAX   = PHASE_W'(HALF_TURN_OUT);
  localparam logic signed [PHASE_W-1:0] PH_MIN   = PHASE_W'(1 - HALF_TURN_OUT);

  logic [THR_W-1:0]    thr_r;
  logic [THR_SQ_W-1:0] thr_sq_r;

  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   en;
  side_t           side_r [NSTG];
  xy_t             x_r [NUM_ITER+1];
  xy_t             y_r [NUM_ITER+1];
  z_t              z_r [NUM_ITER+1];
  logic [SQ_W-1:0] sq_re_r;
  logic [SQ_W-1:0] sq_im_r;
  logic signed [RND_W-1:0]   rnd_r;
  logic signed [PHASE_W-1:0] phase_r;

  // Stage 0 inputs.
  logic                          neg_in;
  xy_t                           x_in;
  xy_t                           y_in;
  logic [SAMPLE_BITS-1:0]        ar;
  logic [SAMPLE_BITS-1:0]        ai;
  xy_t                           x0_nxt;
  xy_t                           y0_nxt;
  z_t                            z0_nxt;
  side_t                         side0_nxt;
  logic [SQ_W-1:0]               sq_re_nxt;
  logic [SQ_W-1:0]               sq_im_nxt;
  logic [PWR_W-1:0]              pwr;
  side_t                         side1_nxt;
  z_t                            rnd_sum;
  z_t                            rnd_shr;
  logic signed [RND_W-1:0]       wrap_val;
  logic signed [PHASE_W-1:0]     phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_W'(THR_RESET);
      thr_sq_r <= THR_SQ_W'(THR_RESET * THR_RESET);
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      thr_sq_r <= THR_SQ_W'(thr_r) * THR_SQ_W'(thr_r);
    end
  end

  assign en[NSTG] = out_chan.ready;
  for (genvar s = 0; s < NSTG; s++) begin : g_en
    assign en[s] = !vld_r[s] || en[s+1];
  end
  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_chan.valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  always_comb begin
    neg_in = in_chan.real_part[SAMPLE_BITS-1];
    x_in   = {{(XY_W-SAMPLE_BITS-GUARD_SHIFT){in_chan.real_part[SAMPLE_BITS-1]}},
              in_chan.real_part, {GUARD_SHIFT{1'b0}}};
    y_in   = {{(XY_W-SAMPLE_BITS-GUARD_SHIFT){in_chan.imag_part[SAMPLE_BITS-1]}},
              in_chan.imag_part, {GUARD_SHIFT{1'b0}}};
    x0_nxt = neg_in ? -x_in : x_in;
    y0_nxt = neg_in ? -y_in : y_in;
    if (!neg_in) begin
      z0_nxt = '0;
    end else if (!in_chan.imag_part[SAMPLE_BITS-1]) begin
      z0_nxt = z_t'(HALF_TURN_FINE);
    end else begin
      z0_nxt = -z_t'(HALF_TURN_FINE);
    end
    ar = neg_in ? (~in_chan.real_part + 1'b1) : in_chan.real_part;
    ai = in_chan.imag_part[SAMPLE_BITS-1] ? (~in_chan.imag_part + 1'b1)
                                          : in_chan.imag_part;
    sq_re_nxt = SQ_W'(ar) * SQ_W'(ar);
    sq_im_nxt = SQ_W'(ai) * SQ_W'(ai);
    side0_nxt.last  = in_chan.last_point;
    side0_nxt.zero  = (in_chan.real_part == '0) && (in_chan.imag_part == '0);
    side0_nxt.gated = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      side_r[0] <= side0_nxt;
      sq_re_r   <= sq_re_nxt;
      sq_im_r   <= sq_im_nxt;
    end
  end

  always_comb begin
    pwr             = PWR_W'(sq_re_r) + PWR_W'(sq_im_r);
    side1_nxt       = side_r[0];
    side1_nxt.gated = PWR_W'(thr_sq_r) > pwr;
  end

  for (genvar k = 0; k < NUM_ITER; k++) begin : g_cordic
    xy_t  xs;
    xy_t  ys;
    logic dn;

    assign xs = x_r[k] >>> k;
    assign ys = y_r[k] >>> k;
    assign dn = y_r[k][XY_W-1];

    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        x_r[k+1]    <= dn ? (x_r[k] - ys) : (x_r[k] + ys);
        y_r[k+1]    <= dn ? (y_r[k] + xs) : (y_r[k] - xs);
        z_r[k+1]    <= dn ? (z_r[k] - z_t'(ATAN_TABLE[k])) : (z_r[k] + z_t'(ATAN_TABLE[k]));
        side_r[k+1] <= (k == 0) ? side1_nxt : side_r[k];
      end
    end
  end

  always_comb begin
    rnd_sum = z_r[NUM_ITER] + z_t'(RND_HALF);
    rnd_shr = rnd_sum >>> RND_SHIFT;
    if (rnd_r <= -R_HALF) begin
      wrap_val = rnd_r + R_FULL;
    end else if (rnd_r > R_HALF) begin
      wrap_val = rnd_r - R_FULL;
    end else begin
      wrap_val = rnd_r;
    end
    if (side_r[RND_STG].gated || side_r[RND_STG].zero) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = wrap_val[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[RND_STG]) begin
      rnd_r           <= rnd_shr[RND_W-1:0];
      side_r[RND_STG] <= side_r[RND_STG-1];
    end
    if (en[OUT_STG]) begin
      phase_r         <= phase_nxt;
      side_r[OUT_STG] <= side_r[RND_STG];
    end
  end

  assign out_chan.valid           = vld_r[OUT_STG];
  assign out_chan.phase_deg       = phase_r;
  assign out_chan.below_threshold = side_r[OUT_STG].gated;
  assign out_chan.last_out        = side_r[OUT_STG].last;

  a_gated_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.below_threshold |-> out_chan.phase_deg == '0)
    else $error("gated word carries a nonzero phase");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.phase_deg >= PH_MIN) && (out_chan.phase_deg <= PH_MAX))
    else $error("phase outside the half-open turn");

  a_word_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> vld_r[0])
    else $error("accepted word did not enter the pipeline");

endmodule

// File: tb/cpd_tb_pkg.sv
// ============================================================================
// cpd_tb_pkg: phase scoreboard for the gated complex phase testbench
// Predicts the phase word of each accepted point with an independent CORDIC
// and checks the words that leave the block, in order and field by field.
// ============================================================================
package cpd_tb_pkg;
  import cpd_pkg::*;

  localparam int     PHASE_STAGES = 18;
  localparam longint DEG180_FINE  = 64'sd11796480;
  localparam longint PHASE_HALF   = 64'sd11520;
  localparam longint PHASE_FULL   = 64'sd23040;

  // atan(2^-k) in units of 2^-16 degree.
  localparam longint ATAN_FINE [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [PHASE_W-1:0] phase;
    logic                      below;
    logic                      last;
  } phase_word_t;

  class phase_scoreboard;
    phase_word_t expected_words[$];
    longint      threshold;
    int          errors;
    int          points;
    int          gated;
    int          block_ends;

    function new();
      threshold  = 128;
      errors     = 0;
      points     = 0;
      gated      = 0;
      block_ends = 0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] value);
      threshold = longint'(value);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function longint cordic_angle(longint re, longint im);
      longint x, y, z, xs, ys;
      x = re * 65536;
      y = im * 65536;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? DEG180_FINE : -DEG180_FINE;
        x = -x;
        y = -y;
      end
      for (int k = 0; k < PHASE_STAGES; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_FINE[k];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_FINE[k];
        end
      end
      return z;
    endfunction

    function void note_point(logic signed [SAMPLE_BITS-1:0] re_in,
                             logic signed [SAMPLE_BITS-1:0] im_in, logic last_in);
      phase_word_t w;
      longint      re, im, power, ph;
      re      = longint'(re_in);
      im      = longint'(im_in);
      power   = re * re + im * im;
      w.below = (threshold * threshold > power);
      w.last  = last_in;
      ph      = 0;
      if (!w.below && (re != 0 || im != 0)) begin
        ph = (cordic_angle(re, im) + 512) >>> 10;
        if (ph <= -PHASE_HALF) begin
          ph = ph + PHASE_FULL;
        end else if (ph > PHASE_HALF) begin
          ph = ph - PHASE_FULL;
        end
      end
      w.phase = ph[PHASE_W-1:0];
      expected_words.push_back(w);
      points++;
    endfunction

    function void check_word(logic signed [PHASE_W-1:0] phase, logic below, logic last);
      phase_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        $error("result word arrived with no point pending");
        return;
      end
      w = expected_words.pop_front();
      if (below === 1'b1) gated++;
      if (last === 1'b1) block_ends++;
      if (phase !== w.phase) begin
        errors++;
        $error("phase_deg: expected %0d, actual %0d", w.phase, phase);
      end
      if (below !== w.below) begin
        errors++;
        $error("below_threshold: expected %0b, actual %0b", w.below, below);
      end
      if (last !== w.last) begin
        errors++;
        $error("last_out: expected %0b, actual %0b", w.last, last);
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// ============================================================================
// tb_top: testbench for the gated complex phase block
// Drives directed and random complex points under several thresholds and
// idling patterns, including a long output hold, and checks every result word.
// ============================================================================
module tb_top;
  import cpd_pkg::*;
  import cpd_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PART       = 8388607;
  localparam int MIN_PART       = -8388608;
  localparam int MAX_THR        = 8388607;
  localparam int POINTS_PER_SET = 230;
  localparam int NUM_SETS       = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 5000;
  localparam int TAIL_CYCLES    = 40;

  localparam logic signed [SAMPLE_BITS-1:0] PART_HI = SAMPLE_BITS'(MAX_PART);
  localparam logic signed [SAMPLE_BITS-1:0] PART_LO = SAMPLE_BITS'(MIN_PART);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          last;
  } point_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;

  cpd_in_if  in_chan();
  cpd_out_if out_chan();

  gated_complex_phase_degrees_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  phase_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  bit              hold_requested;
  bit              hold_done;
  int              quiet_cycles;
  int              cur_threshold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      sb.note_point(in_chan.real_part, in_chan.imag_part, in_chan.last_point);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_word(out_chan.phase_deg, out_chan.below_threshold, out_chan.last_out);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no word moved for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    hold_done      = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requested && !hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_point(input logic signed [SAMPLE_BITS-1:0] re,
                            input logic signed [SAMPLE_BITS-1:0] im, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.real_part  <= re;
    in_chan.imag_part  <= im;
    in_chan.last_point <= last;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[THR_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_threshold(value[THR_W-1:0]);
    cur_threshold = value;
    repeat (4) @(posedge clk);
  endtask

  function automatic point_t random_point(int thr);
    point_t p;
    int     pick, span, mag, kind;
    pick   = $urandom_range(99);
    p.last = ($urandom_range(7) == 0);
    p.re   = '0;
    p.im   = '0;
    if (pick < 40) begin
      p.re = SAMPLE_BITS'($urandom());
      p.im = SAMPLE_BITS'($urandom());
    end else if (pick < 65) begin
      span = (thr > 5592404) ? MAX_PART : thr + thr / 2 + 2;
      mag  = $urandom_range(2 * span);
      p.re = SAMPLE_BITS'(mag - span);
      mag  = $urandom_range(2 * span);
      p.im = SAMPLE_BITS'(mag - span);
    end else if (pick < 80) begin
      mag  = $urandom_range(600);
      p.re = SAMPLE_BITS'(mag - 300);
      mag  = $urandom_range(600);
      p.im = SAMPLE_BITS'(mag - 300);
    end else if (pick < 90) begin
      mag  = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(MAX_PART));
      kind = $urandom_range(5);
      case (kind)
        0: begin p.re = SAMPLE_BITS'(mag);  p.im = '0; end
        1: begin p.re = SAMPLE_BITS'(-mag); p.im = '0; end
        2: begin p.re = '0; p.im = SAMPLE_BITS'(mag); end
        3: begin p.re = '0; p.im = SAMPLE_BITS'(-mag); end
        4: begin
          p.re = SAMPLE_BITS'(mag);
          p.im = SAMPLE_BITS'($urandom_range(1) ? mag : -mag);
        end
        default: begin
          p.re = SAMPLE_BITS'(-mag);
          p.im = SAMPLE_BITS'($urandom_range(1) ? mag : -mag);
        end
      endcase
    end else begin
      mag  = $urandom_range(8388608, 1);
      p.re = SAMPLE_BITS'(-mag);
      mag  = $urandom_range(6);
      p.im = SAMPLE_BITS'(mag - 3);
    end
    return p;
  endfunction

  task automatic run_directed();
    send_point(PART_HI, PART_HI, 1'b0);
    send_point(PART_LO, PART_LO, 1'b1);
    send_point(PART_LO, 0, 1'b0);
    send_point(PART_LO, -1, 1'b0);
    send_point(PART_LO, 1, 1'b0);
    send_point(0, PART_HI, 1'b0);
    send_point(0, PART_LO, 1'b0);
    send_point(PART_HI, 0, 1'b0);
    send_point(PART_HI, PART_LO, 1'b1);
    send_point(PART_LO, PART_HI, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(128, 0, 1'b0);
    send_point(127, 0, 1'b0);
    send_point(0, -128, 1'b0);
    send_point(-128, 0, 1'b1);
    send_point(-91, -91, 1'b0);
    send_point(-90, -90, 1'b0);
    send_point(1000, -1, 1'b0);
    send_point(-1000000, -3, 1'b0);
    send_point(1, PART_HI, 1'b1);
    send_point(PART_HI, 1, 1'b0);
    send_point(-1, 0, 1'b1);
  endtask

  initial begin
    int     set_thr [NUM_SETS];
    int     set_send [NUM_SETS];
    int     set_recv [NUM_SETS];
    point_t p;
    sb                 = new();
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_chan.valid      = 1'b0;
    in_chan.real_part  = '0;
    in_chan.imag_part  = '0;
    in_chan.last_point = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_requested     = 1'b0;
    cur_threshold      = 128;
    set_thr  = '{0, MAX_THR, int'($urandom_range(MAX_THR)), 1500,
                 int'($urandom_range(4000)), 128};
    set_send = '{55, 0, 25, 0, 0, 25};
    set_recv = '{0, 55, 25, 0, 0, 25};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int n = 0; n < POINTS_PER_SET / 2; n++) begin
      p = random_point(cur_threshold);
      send_point(p.re, p.im, p.last);
    end
    drain();

    for (int s = 0; s < NUM_SETS; s++) begin
      write_threshold(set_thr[s]);
      send_idle_pct  = set_send[s];
      recv_stall_pct = set_recv[s];
      if (s == 3) hold_requested = 1'b1;
      for (int n = 0; n < POINTS_PER_SET; n++) begin
        p = random_point(cur_threshold);
        send_point(p.re, p.im, p.last);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d points under seven threshold settings; %0d were gated and %0d",
             sb.points, sb.gated, sb.block_ends);
    $display("carried a block end, with no idling, sender gaps, receiver stalls and one long hold.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
